[hw/rtl/htalu_pkg.sv]
// ----------------------------------------------------------------------------
// htalu_pkg: shared types, constants and helpers
// Fixed-point format, operation codes and saturation functions used by the
// tuple ALU lanes, the square-root pipeline and the divider pipeline.
// ----------------------------------------------------------------------------
package htalu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int ROOT_W    = WORD_W + 1;
  localparam int SQ_STEPS  = PROD_W / 2;
  localparam int SQ_LAT    = SQ_STEPS + 1;
  localparam int NUM_W     = WORD_W + FRAC_BITS + 1;
  localparam int DIV_LAT   = NUM_W;
  localparam int LANES     = 4;
  localparam int LEN_W     = 31;

  typedef enum logic [2:0] {
    KIND_ADD   = 3'd0,
    KIND_SUB   = 3'd1,
    KIND_NEG   = 3'd2,
    KIND_SCALE = 3'd3,
    KIND_MAG   = 3'd4,
    KIND_NORM  = 3'd5
  } kind_e;

  // Saturate a 33-bit signed value to 32 bits.
  function automatic logic [WORD_W-1:0] sat33(input logic [WORD_W:0] v);
    logic [WORD_W-1:0] r;
    if (v[WORD_W] != v[WORD_W-1]) begin
      r = v[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  // Signed 32-bit result from a magnitude and a sign, saturated.
  function automatic logic [WORD_W-1:0] sat_mag(input logic [PROD_W-1:0] mag,
                                                input logic neg);
    logic [WORD_W-1:0] r;
    if (neg) begin
      if (mag >= {{(PROD_W-WORD_W){1'b0}}, 1'b1, {(WORD_W-1){1'b0}}}) begin
        r = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
        r = WORD_W'(-mag);
      end
    end else begin
      if (mag > {{(PROD_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}}) begin
        r = {1'b0, {(WORD_W-1){1'b1}}};
      end else begin
        r = mag[WORD_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

[hw/rtl/htalu_lane.sv]
// ----------------------------------------------------------------------------
// htalu_lane: one component lane
// Add, subtract, negate and scale for one component, plus the square of the
// component for the magnitude merge. Two register stages.
// ----------------------------------------------------------------------------
module htalu_lane import htalu_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  kind_e             kind_i,
  input  logic [WORD_W-1:0] a_i,
  input  logic [WORD_W-1:0] b_i,
  input  logic [WORD_W-1:0] sc_i,
  output logic [PROD_W-1:0] prod_o,
  output logic [WORD_W-1:0] res_o,
  output logic [WORD_W-1:0] aabs_o,
  output logic              neg_o
);

  logic [WORD_W-1:0] aabs, scabs, mulb, simple_d;
  logic [PROD_W-1:0] prod_d, rnd;

  logic [PROD_W-1:0] prod_q;
  logic [WORD_W-1:0] simple_q, aabs1_q, res_q, aabs2_q;
  kind_e             kind_q;
  logic              aneg_q, sneg_q, neg2_q;

  always_comb begin
    aabs  = a_i[WORD_W-1]  ? WORD_W'(-a_i)  : a_i;
    scabs = sc_i[WORD_W-1] ? WORD_W'(-sc_i) : sc_i;
    mulb  = (kind_i == KIND_SCALE) ? scabs : aabs;
    prod_d = PROD_W'(aabs) * PROD_W'(mulb);
    case (kind_i)
      KIND_ADD: simple_d = sat33({a_i[WORD_W-1], a_i} + {b_i[WORD_W-1], b_i});
      KIND_SUB: simple_d = sat33({a_i[WORD_W-1], a_i} - {b_i[WORD_W-1], b_i});
      KIND_NEG: simple_d = sat33((WORD_W+1)'(-{a_i[WORD_W-1], a_i}));
      default:  simple_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d;
      simple_q <= simple_d;
      aabs1_q  <= aabs;
      kind_q   <= kind_i;
      aneg_q   <= a_i[WORD_W-1];
      sneg_q   <= a_i[WORD_W-1] ^ sc_i[WORD_W-1];
    end
  end

  // Round to nearest, ties away from zero, on the magnitude.
  assign rnd = (prod_q + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q   <= (kind_q == KIND_SCALE) ? sat_mag(rnd, sneg_q) : simple_q;
      aabs2_q <= aabs1_q;
      neg2_q  <= aneg_q;
    end
  end

  assign prod_o = prod_q;
  assign res_o  = res_q;
  assign aabs_o = aabs2_q;
  assign neg_o  = neg2_q;

endmodule

[hw/rtl/htalu_sqrt.sv]
// ----------------------------------------------------------------------------
// htalu_sqrt: pipelined integer square root
// One result bit per stage, then a rounding stage (round to nearest).
// ----------------------------------------------------------------------------
module htalu_sqrt import htalu_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [PROD_W-1:0] rad_i,
  output logic [ROOT_W-1:0] root_o
);

  localparam int REM_W = WORD_W + 3;

  logic [PROD_W-1:0]   rad_q  [SQ_STEPS];
  logic [REM_W-1:0]    rem_q  [SQ_STEPS];
  logic [WORD_W-1:0]   root_q [SQ_STEPS];
  logic [PROD_W-1:0]   rad_d  [SQ_STEPS];
  logic [REM_W-1:0]    rem_d  [SQ_STEPS];
  logic [WORD_W-1:0]   root_d [SQ_STEPS];
  logic [ROOT_W-1:0]   out_q;

  always_comb begin
    logic [PROD_W-1:0] rin;
    logic [REM_W-1:0]  qin, t, trial;
    logic [WORD_W-1:0] oin;
    for (int k = 0; k < SQ_STEPS; k++) begin
      rin = (k == 0) ? rad_i : rad_q[k-1];
      qin = (k == 0) ? '0 : rem_q[k-1];
      oin = (k == 0) ? '0 : root_q[k-1];
      t     = {qin[REM_W-3:0], rin[PROD_W-1:PROD_W-2]};
      trial = {1'b0, oin, 2'b01};
      rad_d[k] = rin << 2;
      if (t >= trial) begin
        rem_d[k]  = t - trial;
        root_d[k] = {oin[WORD_W-2:0], 1'b1};
      end else begin
        rem_d[k]  = t;
        root_d[k] = {oin[WORD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SQ_STEPS; k++) begin
        rad_q[k]  <= rad_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
      out_q <= ROOT_W'(root_q[SQ_STEPS-1])
             + ROOT_W'(rem_q[SQ_STEPS-1] > REM_W'(root_q[SQ_STEPS-1]));
    end
  end

  assign root_o = out_q;

endmodule

[hw/rtl/htalu_div.sv]
// ----------------------------------------------------------------------------
// htalu_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module htalu_div import htalu_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [ROOT_W-1:0] den_i,
  output logic [NUM_W-1:0]  quo_o
);

  localparam int REM_W = ROOT_W + 1;

  logic [NUM_W-1:0]  num_q [DIV_LAT];
  logic [REM_W-1:0]  rem_q [DIV_LAT];
  logic [NUM_W-1:0]  quo_q [DIV_LAT];
  logic [ROOT_W-1:0] den_q [DIV_LAT];
  logic [NUM_W-1:0]  num_d [DIV_LAT];
  logic [REM_W-1:0]  rem_d [DIV_LAT];
  logic [NUM_W-1:0]  quo_d [DIV_LAT];
  logic [ROOT_W-1:0] den_d [DIV_LAT];

  always_comb begin
    logic [NUM_W-1:0]  nin, qin;
    logic [REM_W-1:0]  rin, t;
    logic [ROOT_W-1:0] din;
    for (int k = 0; k < DIV_LAT; k++) begin
      nin = (k == 0) ? num_i : num_q[k-1];
      rin = (k == 0) ? '0    : rem_q[k-1];
      qin = (k == 0) ? '0    : quo_q[k-1];
      din = (k == 0) ? den_i : den_q[k-1];
      t = {rin[REM_W-2:0], nin[NUM_W-1]};
      num_d[k] = nin << 1;
      den_d[k] = din;
      if (t >= REM_W'(din)) begin
        rem_d[k] = t - REM_W'(din);
        quo_d[k] = {qin[NUM_W-2:0], 1'b1};
      end else begin
        rem_d[k] = t;
        quo_d[k] = {qin[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        num_q[k] <= num_d[k];
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        den_q[k] <= den_d[k];
      end
    end
  end

  assign quo_o = quo_q[DIV_LAT-1];

endmodule

[hw/rtl/homogeneous_tuple_alu_core.sv]
// ----------------------------------------------------------------------------
// homogeneous_tuple_alu_core: four-component Q16.16 tuple ALU
// Add, subtract, negate, scale, magnitude and normalize on (x, y, z, w).
// ----------------------------------------------------------------------------
// Every operation passes the lane, square-root and divider stages and the
// output register; all kinds share one fixed-length pipeline. Throughput:
// one item per cycle while the output is not stalled; the whole pipeline
// advances whenever the output register is empty or its item is taken, so
// ready follows that. The depth is set by the bit-per-stage square root
// and the four bit-per-stage lane dividers. Reset clears only the valid bits.
module homogeneous_tuple_alu_core import htalu_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               kind_i,
  input  logic signed [WORD_W-1:0] a_x_i,
  input  logic signed [WORD_W-1:0] a_y_i,
  input  logic signed [WORD_W-1:0] a_z_i,
  input  logic signed [WORD_W-1:0] a_w_i,
  input  logic signed [WORD_W-1:0] b_x_i,
  input  logic signed [WORD_W-1:0] b_y_i,
  input  logic signed [WORD_W-1:0] b_z_i,
  input  logic signed [WORD_W-1:0] b_w_i,
  input  logic signed [WORD_W-1:0] scale_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [WORD_W-1:0] r_x_o,
  output logic signed [WORD_W-1:0] r_y_o,
  output logic signed [WORD_W-1:0] r_z_o,
  output logic signed [WORD_W-1:0] r_w_o,
  output logic [LEN_W-1:0]         length_o
);

  // Sideband that rides along the square-root stages.
  typedef struct packed {
    kind_e                        kind;
    logic [LANES-1:0][WORD_W-1:0] res;
    logic [LANES-1:0][WORD_W-1:0] aabs;
    logic [LANES-1:0]             neg;
  } sq_side_t;

  // Sideband that rides along the divider stages.
  typedef struct packed {
    kind_e                        kind;
    logic [LANES-1:0][WORD_W-1:0] res;
    logic [LANES-1:0]             neg;
    logic [LEN_W-1:0]             len;
    logic                         mzero;
  } dv_side_t;

  logic                         en;
  logic [LANES-1:0][WORD_W-1:0] a_in, b_in;
  logic [LANES-1:0][PROD_W-1:0] prod;
  logic [LANES-1:0][WORD_W-1:0] res, aabs;
  logic [LANES-1:0]             neg;
  logic [LANES-1:0][NUM_W-1:0]  quo;
  logic [LANES-1:0][NUM_W-1:0]  num;
  logic [ROOT_W-1:0]            root;

  logic                         vld1_q, vld2_q;
  kind_e                        kind1_q, kind2_q;
  logic [PROD_W-1:0]            sum_q;
  sq_side_t                     sq_q [SQ_LAT];
  dv_side_t                     dv_q [DIV_LAT];
  logic                         sq_vld_q [SQ_LAT];
  logic                         dv_vld_q [DIV_LAT];
  dv_side_t                     dv_in;
  sq_side_t                     sq_in;
  sq_side_t                     sq_last;
  dv_side_t                     dv_last;

  logic                         out_vld_q;
  logic [LANES-1:0][WORD_W-1:0] r_q;
  logic [LEN_W-1:0]             len_q;

  // Advance everything when the output slot is free or being drained.
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  assign a_in = {a_w_i, a_z_i, a_y_i, a_x_i};
  assign b_in = {b_w_i, b_z_i, b_y_i, b_x_i};

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    htalu_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .kind_i (kind_e'(kind_i)),
      .a_i    (a_in[l]),
      .b_i    (b_in[l]),
      .sc_i   (scale_i),
      .prod_o (prod[l]),
      .res_o  (res[l]),
      .aabs_o (aabs[l]),
      .neg_o  (neg[l])
    );
  end

  // Front control: valid and kind alongside the lane stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en) begin
      vld1_q <= in_valid_i;
      vld2_q <= vld1_q;
    end
  end

  // Merge stage: sum of squares of x, y, z (w is not part of the magnitude).
  always_ff @(posedge clk_i) begin
    if (en) begin
      kind1_q <= kind_e'(kind_i);
      kind2_q <= kind1_q;
      sum_q   <= prod[0] + prod[1] + prod[2];
    end
  end

  htalu_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum_q),
    .root_o (root)
  );

  always_comb begin
    sq_in.kind = kind2_q;
    sq_in.res  = res;
    sq_in.aabs = aabs;
    sq_in.neg  = neg;
  end

  // Hold the lane results while the root is worked out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SQ_LAT; k++) begin
        sq_vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      sq_vld_q[0] <= vld2_q;
      for (int k = 1; k < SQ_LAT; k++) begin
        sq_vld_q[k] <= sq_vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0].kind <= sq_in.kind;
      sq_q[0].res  <= sq_in.res;
      sq_q[0].aabs <= sq_in.aabs;
      sq_q[0].neg  <= sq_in.neg;
      for (int k = 1; k < SQ_LAT; k++) begin
        sq_q[k].kind <= sq_q[k-1].kind;
        sq_q[k].res  <= sq_q[k-1].res;
        sq_q[k].aabs <= sq_q[k-1].aabs;
        sq_q[k].neg  <= sq_q[k-1].neg;
      end
    end
  end

  assign sq_last = sq_q[SQ_LAT-1];

  // Normalize numerators: |c| scaled up, plus half the divisor for rounding.
  for (genvar l = 0; l < LANES; l++) begin : g_div
    assign num[l] = ({1'b0, sq_last.aabs[l], {FRAC_BITS{1'b0}}})
                  + NUM_W'(root[ROOT_W-1:1]);
    htalu_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num[l]),
      .den_i (root),
      .quo_o (quo[l])
    );
  end

  always_comb begin
    dv_in.kind  = sq_last.kind;
    dv_in.res   = sq_last.res;
    dv_in.neg   = sq_last.neg;
    dv_in.mzero = (root == '0);
    if (root[ROOT_W-1:LEN_W] != '0) begin
      dv_in.len = {LEN_W{1'b1}};
    end else begin
      dv_in.len = root[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        dv_vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      dv_vld_q[0] <= sq_vld_q[SQ_LAT-1];
      for (int k = 1; k < DIV_LAT; k++) begin
        dv_vld_q[k] <= dv_vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0].kind  <= dv_in.kind;
      dv_q[0].res   <= dv_in.res;
      dv_q[0].neg   <= dv_in.neg;
      dv_q[0].len   <= dv_in.len;
      dv_q[0].mzero <= dv_in.mzero;
      for (int k = 1; k < DIV_LAT; k++) begin
        dv_q[k].kind  <= dv_q[k-1].kind;
        dv_q[k].res   <= dv_q[k-1].res;
        dv_q[k].neg   <= dv_q[k-1].neg;
        dv_q[k].len   <= dv_q[k-1].len;
        dv_q[k].mzero <= dv_q[k-1].mzero;
      end
    end
  end

  assign dv_last = dv_q[DIV_LAT-1];

  // Output register: pick the result for the kind, saturate quotients.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      case (dv_last.kind)
        KIND_ADD, KIND_SUB, KIND_NEG, KIND_SCALE: begin
          r_q   <= dv_last.res;
          len_q <= '0;
        end
        KIND_MAG: begin
          r_q   <= '0;
          len_q <= dv_last.len;
        end
        KIND_NORM: begin
          for (int l = 0; l < LANES; l++) begin
            r_q[l] <= dv_last.mzero ? '0
                    : sat_mag(PROD_W'(quo[l]), dv_last.neg[l]);
          end
          len_q <= dv_last.len;
        end
        default: begin
          r_q   <= '0;
          len_q <= '0;
        end
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign r_x_o       = r_q[0];
  assign r_y_o       = r_q[1];
  assign r_z_o       = r_q[2];
  assign r_w_o       = r_q[3];
  assign length_o    = len_q;

endmodule

[tb/tb_homogeneous_tuple_alu_core.sv]
// ----------------------------------------------------------------------------
// Tuple ALU core testbench
// Drives add, subtract, negate, scale, magnitude, normalize and the unused
// kinds through the core with bursty input and a stalling sink, predicts each
// result in fixed point and checks every output field in order.
// ----------------------------------------------------------------------------
module tb_homogeneous_tuple_alu_core;
  import htalu_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] ax, ay, az, aw, bx, by, bz, bw, sc;
  } op_t;

  typedef struct packed {
    logic [31:0] rx, ry, rz, rw;
    logic [30:0] len;
  } res_t;

  int unsigned errors = 0;

  // Count each mismatch and print a line for the first 40.
  task automatic report(input string what);
    errors++;
    if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Saturate a 64-bit signed value to the 32-bit range.
  function automatic logic [31:0] clamp(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] from_mag(input logic [63:0] m, input bit neg);
    if (neg) return (m >= 64'h80000000) ? 32'h80000000 : 32'(-m);
    return (m > 64'h7fffffff) ? 32'h7fffffff : m[31:0];
  endfunction

  function automatic logic [63:0] absw(input logic [31:0] v);
    longint s;
    s = longint'($signed(v));
    return (s < 0) ? 64'(-s) : 64'(s);
  endfunction

  // Rounded-to-nearest integer square root, digit by digit.
  function automatic logic [63:0] root_round(input logic [63:0] s);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > s) bt >>= 2;
    while (bt != 0) begin
      if (s >= res + bt) begin
        s -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    if (s > res) res++;
    return res;
  endfunction

  function automatic res_t compute_tuple(input op_t o);
    logic [31:0] a [4];
    logic [31:0] b [4];
    logic [63:0] p, s, m, num;
    res_t r;
    a = '{o.ax, o.ay, o.az, o.aw};
    b = '{o.bx, o.by, o.bz, o.bw};
    r = '0;
    for (int i = 0; i < 4; i++) begin
      logic [31:0] c;
      c = 0;
      case (o.kind)
        KIND_ADD: c = clamp(longint'($signed(a[i])) + longint'($signed(b[i])));
        KIND_SUB: c = clamp(longint'($signed(a[i])) - longint'($signed(b[i])));
        KIND_NEG: c = clamp(-longint'($signed(a[i])));
        KIND_SCALE: begin
          p = absw(a[i]) * absw(o.sc);
          p = (p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
          c = from_mag(p, a[i][31] != o.sc[31]);
        end
        default: c = 0;
      endcase
      case (i)
        0: r.rx = c;
        1: r.ry = c;
        2: r.rz = c;
        default: r.rw = c;
      endcase
    end
    if (o.kind == KIND_MAG || o.kind == KIND_NORM) begin
      s = 0;
      for (int i = 0; i < 3; i++) s += absw(a[i]) * absw(a[i]);
      m = root_round(s);
      r.len = (m > 64'h7fffffff) ? 31'h7fffffff : m[30:0];
      if (o.kind == KIND_NORM && m != 0) begin
        logic [31:0] q [4];
        for (int i = 0; i < 4; i++) begin
          num = absw(a[i]) << FRAC_BITS;
          q[i] = from_mag((num + (m >> 1)) / m, a[i][31]);
        end
        r.rx = q[0]; r.ry = q[1]; r.rz = q[2]; r.rw = q[3];
      end
    end
    return r;
  endfunction

  class tuple_scoreboard;
    res_t pending[$];
    int unsigned seen;
    function void note_input(op_t o);
      pending.push_back(compute_tuple(o));
    endfunction
    task check_result(res_t got);
      res_t exp_r;
      seen++;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      exp_r = pending.pop_front();
      if (got.rx !== exp_r.rx) report($sformatf("r_x %h exp %h", got.rx, exp_r.rx));
      if (got.ry !== exp_r.ry) report($sformatf("r_y %h exp %h", got.ry, exp_r.ry));
      if (got.rz !== exp_r.rz) report($sformatf("r_z %h exp %h", got.rz, exp_r.rz));
      if (got.rw !== exp_r.rw) report($sformatf("r_w %h exp %h", got.rw, exp_r.rw));
      if (got.len !== exp_r.len) report($sformatf("len %h exp %h", got.len, exp_r.len));
    endtask
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_ready_i = 0;
  logic in_ready_o, out_valid_o;
  logic [2:0] kind_i = 0;
  logic signed [31:0] a_x_i = 0, a_y_i = 0, a_z_i = 0, a_w_i = 0;
  logic signed [31:0] b_x_i = 0, b_y_i = 0, b_z_i = 0, b_w_i = 0, scale_i = 0;
  logic signed [31:0] r_x_o, r_y_o, r_z_o, r_w_o;
  logic [30:0] length_o;

  homogeneous_tuple_alu_core dut (.*);

  tuple_scoreboard board = new();
  longint cycles = 0;
  int unsigned sent = 0;
  bit sink_on = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Abort the run if it hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Sink: stall at random, with phases of no stalling at all.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      board.check_result('{r_x_o, r_y_o, r_z_o, r_w_o, length_o});
    if (sink_on) begin
      if ((cycles / 300) % 3 == 0) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 0;
      3: return $urandom_range(0, 1) ? 32'hffffffff : 32'h00010000;
      4: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
      default: return $urandom;
    endcase
  endfunction

  // Present one item and hold it until accepted.
  task automatic send_item(input op_t o);
    in_valid_i <= 1'b1;
    kind_i <= o.kind;
    a_x_i <= o.ax; a_y_i <= o.ay; a_z_i <= o.az; a_w_i <= o.aw;
    b_x_i <= o.bx; b_y_i <= o.by; b_z_i <= o.bz; b_w_i <= o.bw;
    scale_i <= o.sc;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_input(o);
    sent++;
  endtask

  task automatic idle_gap(input int n);
    if (n == 0) return;
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  initial begin
    op_t o;
    logic [31:0] mx, mn;
    int burst;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    sink_on = 1;
    @(posedge clk_i);
    // Directed: field extremes, each kind, zero magnitude, negating the minimum,
    // the unused kinds.
    send_item('{KIND_ADD, mx, mn, mx, 1, 1, mn, mx, 0, 0});
    send_item('{KIND_SUB, mn, mx, 0, mn, 1, mn, mn, mx, 0});
    send_item('{KIND_NEG, mn, mx, 0, 32'hffffffff, 0, 0, 0, 0, 0});
    send_item('{KIND_SCALE, mx, mn, 32'h00018000, 32'hffff0000, 0, 0, 0, 0, mn});
    send_item('{KIND_SCALE, 1, 32'hffffffff, 3, mx, 0, 0, 0, 0, 32'h00008000});
    send_item('{KIND_MAG, mn, mn, mn, mx, 0, 0, 0, 0, 0});
    send_item('{KIND_MAG, mx, mx, mx, 0, 0, 0, 0, 0, 0});
    send_item('{KIND_MAG, 0, 0, 0, 5, 0, 0, 0, 0, 0});
    send_item('{KIND_NORM, 0, 0, 0, mx, 0, 0, 0, 0, 0});
    send_item('{KIND_NORM, 1, 0, 0, mn, 0, 0, 0, 0, 0});
    send_item('{KIND_NORM, mn, mx, 1, mx, 0, 0, 0, 0, 0});
    send_item('{KIND_NORM, 32'h00030000, 32'hfffc0000, 0, 32'h00010000, 0, 0, 0, 0, 0});
    send_item('{3'd6, mx, mx, mx, mx, mx, mx, mx, mx, mx});
    send_item('{3'd7, mn, mn, mn, mn, mn, mn, mn, mn, mn});
    // Random bursts with random gaps.
    while (sent < 714) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        o.kind = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
        o.ax = pick_word(); o.ay = pick_word(); o.az = pick_word();
        o.aw = pick_word(); o.bx = pick_word(); o.by = pick_word();
        o.bz = pick_word(); o.bw = pick_word(); o.sc = pick_word();
        send_item(o);
      end
      idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 12));
    end
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("sent %0d items across all kinds, checked %0d results",
             sent, board.seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end
endmodule
